/* hdl/srb_pkg.sv */
package srb_pkg;

  // Outcome codes reported with every result beat.
  typedef enum logic [2:0] {
    OUT_RELEASED   = 3'd0,
    OUT_REPLAYED   = 3'd1,
    OUT_BUFFERED   = 3'd2,
    OUT_DUPLICATE  = 3'd3,
    OUT_BAD_STREAM = 3'd4
  } outcome_e;

  localparam int STREAM_BITS   = 5;
  localparam int SEQ_BITS      = 31;
  localparam int PAY_BITS      = 64;
  // Slot offset within one ring; rings hold at most 32 slots.
  localparam int SLOT_BITS     = 5;

  localparam int QUEUE_ENTRIES = 4;
  localparam int QUEUE_PTR_BITS   = 2;
  localparam int QUEUE_LEVEL_BITS = 3;

  typedef struct packed {
    logic [STREAM_BITS-1:0] stream_number;
    logic [SEQ_BITS-1:0]    sequence_number;
    logic [PAY_BITS-1:0]    message_payload;
  } item_t;

  typedef struct packed {
    outcome_e               outcome;
    logic [STREAM_BITS-1:0] out_stream;
    logic [SEQ_BITS-1:0]    out_sequence;
    logic [PAY_BITS-1:0]    out_payload;
    logic                   last_of_run;
  } result_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    outcome_e               kind;
    logic [STREAM_BITS-1:0] stream;
    logic [SEQ_BITS-1:0]    seq;
    logic [PAY_BITS-1:0]    payload;
    logic [SLOT_BITS-1:0]   slot;
  } cmd_t;

  // Status reported by the back to the front.
  typedef struct packed {
    logic                   clearing;
    logic                   done;
    logic [STREAM_BITS-1:0] stream;
    logic [SEQ_BITS-1:0]    expected;
  } back_status_t;

endpackage

/* hdl/srb_queue.sv */
module srb_queue (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  srb_pkg::cmd_t                         push_cmd,
  input  logic                                  pop,
  output srb_pkg::cmd_t                         head,
  output logic [srb_pkg::QUEUE_LEVEL_BITS-1:0]  level
);
  import srb_pkg::*;

  cmd_t                      entries [QUEUE_ENTRIES];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;

  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

endmodule

/* hdl/srb_front.sv */
module srb_front #(
  parameter int STREAMS      = 5,
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  srb_pkg::item_t                        item,
  output logic                                  busy,
  input  srb_pkg::back_status_t                 status,
  input  logic [srb_pkg::QUEUE_LEVEL_BITS-1:0]  level,
  output logic                                  push,
  output srb_pkg::cmd_t                         cmd
);
  import srb_pkg::*;

  localparam int SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam logic [PAY_BITS-1:0] PayMask = PAY_BITS'((65'd1 << PAYLOAD_BITS) - 65'd1);
  // floor(2^32 / DEPTH): quotient estimate is exact or one low
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / DEPTH);

  logic [SEQ_BITS-1:0] expected [STREAMS];
  logic                run_pending;

  logic                   stage_valid;
  outcome_e               stage_kind;
  logic [STREAM_BITS-1:0] stage_stream;
  logic [SEQ_BITS-1:0]    stage_seq;
  logic [PAY_BITS-1:0]    stage_payload;
  logic [SEQ_BITS-1:0]    stage_quot;

  logic                   accept;
  logic                   stream_ok;
  logic [SW-1:0]          sidx;
  logic [SEQ_BITS-1:0]    exp_cur;
  outcome_e               kind;
  logic [62:0]            prod;
  logic [SEQ_BITS-1:0]    quot_depth;
  logic [SEQ_BITS-1:0]    rem_wide;
  logic [6:0]             rem;
  logic [6:0]             slot_fix;

  assign busy   = status.clearing | run_pending |
                  (level >= QUEUE_LEVEL_BITS'(QUEUE_ENTRIES - 1));
  assign accept = start & ~busy;

  assign stream_ok = (item.stream_number != '0) &&
                     (item.stream_number <= STREAM_BITS'(STREAMS));
  assign sidx      = SW'(item.stream_number - 5'd1);

  always_comb begin
    exp_cur = '0;
    for (int i = 0; i < STREAMS; i++) begin
      if (sidx == SW'(i)) begin
        exp_cur = expected[i];
      end
    end
  end

  always_comb begin
    if (!stream_ok) begin
      kind = OUT_BAD_STREAM;
    end else if (item.sequence_number < exp_cur) begin
      kind = OUT_DUPLICATE;
    end else if (item.sequence_number > exp_cur) begin
      kind = OUT_BUFFERED;
    end else begin
      kind = OUT_RELEASED;
    end
  end

  assign prod = 63'(item.sequence_number) * 63'(Recip);

  // Second stage: finish the ring offset with one correction step.
  assign quot_depth = SEQ_BITS'(stage_quot * SEQ_BITS'(DEPTH));
  assign rem_wide   = stage_seq - quot_depth;
  assign rem        = rem_wide[6:0];
  assign slot_fix   = (rem >= 7'(DEPTH)) ? (rem - 7'(DEPTH)) : rem;

  assign push        = stage_valid;
  assign cmd.kind    = stage_kind;
  assign cmd.stream  = stage_stream;
  assign cmd.seq     = stage_seq;
  assign cmd.payload = stage_payload;
  assign cmd.slot    = slot_fix[SLOT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_kind    <= kind;
      stage_stream  <= item.stream_number;
      stage_seq     <= item.sequence_number;
      stage_payload <= item.message_payload & PayMask;
      stage_quot    <= prod[62:32];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      run_pending <= 1'b0;
      for (int i = 0; i < STREAMS; i++) begin
        expected[i] <= SEQ_BITS'(1);
      end
    end else begin
      stage_valid <= accept;
      if (accept && kind == OUT_RELEASED) begin
        run_pending <= 1'b1;
      end else if (status.done) begin
        run_pending <= 1'b0;
      end
      for (int i = 0; i < STREAMS; i++) begin
        if (status.done && status.stream == STREAM_BITS'(i + 1)) begin
          expected[i] <= status.expected;
        end
      end
    end
  end

endmodule

/* hdl/srb_back.sv */
module srb_back #(
  parameter int STREAMS      = 5,
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  srb_pkg::cmd_t                         cmd,
  input  logic [srb_pkg::QUEUE_LEVEL_BITS-1:0]  level,
  output logic                                  pop,
  output srb_pkg::back_status_t                 status,
  output logic                                  strobe,
  output srb_pkg::result_t                      result
);
  import srb_pkg::*;

  localparam int NSLOTS = STREAMS * DEPTH;
  localparam int AW     = $clog2(NSLOTS);
  localparam int EW     = 1 + SEQ_BITS + PAYLOAD_BITS;
  localparam int CW     = $clog2(DEPTH + 2);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_CHECK = 3'b100
  } state_t;

  state_t state;

  logic [EW-1:0] slot_mem [NSLOTS];
  logic [EW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [AW-1:0] raddr;

  logic [AW-1:0]          clear_addr;
  logic [AW-1:0]          run_base;
  logic [SLOT_BITS-1:0]   run_slot;
  logic [SEQ_BITS-1:0]    run_exp;
  logic [CW-1:0]          run_count;
  result_t                pend;

  logic                   run_done;
  logic [STREAM_BITS-1:0] run_stream;
  logic [SEQ_BITS-1:0]    run_final;

  logic [AW-1:0]          cmd_base;
  logic [SLOT_BITS-1:0]   cmd_next_slot;
  logic [SLOT_BITS-1:0]   run_next_slot;
  logic                   rd_occ;
  logic [SEQ_BITS-1:0]    rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic                   hit;

  assign cmd_base      = AW'(32'(cmd.stream - 5'd1) * 32'(DEPTH));
  assign cmd_next_slot = (cmd.slot == SLOT_BITS'(DEPTH - 1)) ? '0 : cmd.slot + 1'b1;
  assign run_next_slot = (run_slot == SLOT_BITS'(DEPTH - 1)) ? '0 : run_slot + 1'b1;

  assign rd_occ = rdata[EW-1];
  assign rd_seq = rdata[EW-2 -: SEQ_BITS];
  assign rd_pay = rdata[PAYLOAD_BITS-1:0];
  assign hit    = rd_occ && (rd_seq == run_exp) && (run_count <= CW'(DEPTH));

  assign pop    = (state == ST_IDLE) && (level != '0);
  assign status = '{clearing: (state == ST_CLEAR),
                    done:     run_done,
                    stream:   run_stream,
                    expected: run_final};

  always_comb begin
    we    = 1'b0;
    waddr = run_base + AW'(run_slot);
    wdata = {1'b0, rd_seq, rd_pay};
    raddr = run_base + AW'(run_next_slot);
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clear_addr;
        wdata = '0;
      end
      ST_IDLE: begin
        raddr = cmd_base + AW'(cmd_next_slot);
        if (pop && cmd.kind == OUT_BUFFERED) begin
          we    = 1'b1;
          waddr = cmd_base + AW'(cmd.slot);
          wdata = {1'b1, cmd.seq, cmd.payload[PAYLOAD_BITS-1:0]};
        end
      end
      ST_CHECK: begin
        // drop the slot's occupied mark as it replays
        we = hit;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
    rdata <= slot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.out_stream   <= cmd.stream;
      result.out_sequence <= cmd.seq;
      result.out_payload  <= cmd.payload;
      result.outcome      <= cmd.kind;
      result.last_of_run  <= 1'b1;
      pend.outcome        <= cmd.kind;
      pend.out_stream     <= cmd.stream;
      pend.out_sequence   <= cmd.seq;
      pend.out_payload    <= cmd.payload;
      pend.last_of_run    <= 1'b0;
      run_base            <= cmd_base;
      run_slot            <= cmd_next_slot;
      run_exp             <= cmd.seq + 1'b1;
      run_count           <= CW'(1);
    end else if (state == ST_CHECK) begin
      result.outcome      <= pend.outcome;
      result.out_stream   <= pend.out_stream;
      result.out_sequence <= pend.out_sequence;
      result.out_payload  <= pend.out_payload;
      result.last_of_run  <= ~hit;
      run_stream          <= pend.out_stream;
      run_final           <= run_exp;
      if (hit) begin
        pend.outcome      <= OUT_REPLAYED;
        pend.out_sequence <= run_exp;
        pend.out_payload  <= PAY_BITS'(rd_pay);
        run_slot          <= run_next_slot;
        run_exp           <= run_exp + 1'b1;
        run_count         <= run_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clear_addr <= '0;
      strobe     <= 1'b0;
      run_done   <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      run_done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (clear_addr == AW'(NSLOTS - 1)) begin
            state <= ST_IDLE;
          end else begin
            clear_addr <= clear_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop) begin
            if (cmd.kind == OUT_RELEASED) begin
              state <= ST_CHECK;
            end else begin
              strobe <= 1'b1;
            end
          end
        end
        ST_CHECK: begin
          strobe <= 1'b1;
          if (!hit) begin
            run_done <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/sequence_reorder_buffer.sv */
// A message is staged in the front and queued; a bad-stream, duplicate or buffered message gives
// its single beat once popped, a release beat comes from ST_CHECK, and each replay follows in the
// next cycle. Throughput: one non-releasing message per cycle while busy is low; a release holds
// busy until its run of N beats has gone out, bounded by the replay loop over the slot memory read
// port. Reset: rst clears the queue and expected numbers (all 1), then a clearing pass over all
// STREAMS*DEPTH slots marks every slot empty with busy high; the receiver cannot stall results.
module sequence_reorder_buffer #(
  parameter int STREAMS      = 5,
  parameter int DEPTH        = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  srb_pkg::item_t   item,
  output logic             busy,
  output logic             strobe,
  output srb_pkg::result_t result
);
  import srb_pkg::*;

  // Front: accept a beat, classify it against the stream's expected number and
  // compute its ring offset. Back: own the slot memory and sequence release runs.
  // The short queue between them lets buffered and dropped beats stream through.
  cmd_t                        push_cmd;
  cmd_t                        head;
  logic                        push;
  logic                        pop;
  logic [QUEUE_LEVEL_BITS-1:0] level;
  back_status_t                status;

  srb_front #(
    .STREAMS      (STREAMS),
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .status (status),
    .level  (level),
    .push   (push),
    .cmd    (push_cmd)
  );

  // Hold classified commands until the back is free to take them.
  srb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .level    (level)
  );

  // Advance through release runs; report the final expected number on the
  // last beat so the front can unblock the next message.
  srb_back #(
    .STREAMS      (STREAMS),
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cmd    (head),
    .level  (level),
    .pop    (pop),
    .status (status),
    .strobe (strobe),
    .result (result)
  );

endmodule

/* dv/tb_sequence_reorder_buffer.sv */
`timescale 1ns / 100ps

module tb_sequence_reorder_buffer;
  import srb_pkg::*;

  localparam int STREAMS       = 5;
  localparam int DEPTH         = 32;
  localparam int PAYLOAD_BITS  = 64;
  localparam logic [PAY_BITS-1:0] PAY_MASK = {PAY_BITS{1'b1}} >> (PAY_BITS - PAYLOAD_BITS);
  localparam int RANDOM_ITEMS  = 110;
  // Longest run is DEPTH+1 beats.
  localparam int SETTLE_CYCLES = 48;
  localparam int CYCLE_LIMIT   = 200000;

  // One row of the directed table. When typed is set, the expected beat is the
  // input echoed back with outcome want and last_of_run high.
  typedef struct packed {
    item_t    msg;
    logic     typed;
    outcome_e want;
  } stim_row_t;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  item_t   item  = '0;
  logic    busy;
  logic    strobe;
  result_t result;

  // Shadow of the block: next expected number per stream and the slot rings.
  logic [SEQ_BITS-1:0] shadow_exp [STREAMS];
  logic [SEQ_BITS-1:0] ring_seq [STREAMS][DEPTH];
  logic [PAY_BITS-1:0] ring_pay [STREAMS][DEPTH];
  logic                ring_full[STREAMS][DEPTH];

  result_t   run_beats[$];      // beats caused by the message just accepted
  result_t   pending_beats[$];  // beats still owed by the block, oldest first
  stim_row_t directed_rows[$];
  result_t   head_beat;
  int        mismatch_count = 0;
  int        burst_left     = 3;
  int        random_items   = 0;

  sequence_reorder_buffer #(
    .STREAMS     (STREAMS),
    .DEPTH       (DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .strobe(strobe),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Work out every beat one message causes and advance the shadow state.
  function automatic void predict_delivery(input item_t msg);
    logic [STREAM_BITS-1:0] sn;
    logic [SEQ_BITS-1:0]    sq;
    logic [SEQ_BITS-1:0]    nxt;
    result_t                beat;
    int                     s;
    int                     idx;
    run_beats.delete();
    sn = msg.stream_number;
    sq = msg.sequence_number;
    beat.outcome      = OUT_BAD_STREAM;
    beat.out_stream   = sn;
    beat.out_sequence = sq;
    beat.out_payload  = msg.message_payload & PAY_MASK;
    beat.last_of_run  = 1'b1;
    if (sn < 1 || sn > STREAMS) begin
      // Reject without touching any stream.
      run_beats.push_back(beat);
    end else begin
      s   = sn - 1;
      nxt = shadow_exp[s];
      if (sq < nxt) begin
        beat.outcome = OUT_DUPLICATE;
        run_beats.push_back(beat);
      end else if (sq > nxt) begin
        // Park ahead of the gap; whatever sat in the slot is lost.
        idx = int'(sq % DEPTH);
        ring_seq[s][idx]  = sq;
        ring_pay[s][idx]  = beat.out_payload;
        ring_full[s][idx] = 1'b1;
        beat.outcome = OUT_BUFFERED;
        run_beats.push_back(beat);
      end else begin
        beat.outcome     = OUT_RELEASED;
        beat.last_of_run = 1'b0;
        run_beats.push_back(beat);
        nxt = nxt + 1'b1;
        // Replay while the next slot holds exactly the next number; a stale
        // entry stops the run and stays parked.
        while (run_beats.size() < DEPTH + 1 && ring_full[s][nxt % DEPTH] &&
               ring_seq[s][nxt % DEPTH] == nxt) begin
          idx = int'(nxt % DEPTH);
          ring_full[s][idx] = 1'b0;
          beat.outcome      = OUT_REPLAYED;
          beat.out_sequence = nxt;
          beat.out_payload  = ring_pay[s][idx];
          run_beats.push_back(beat);
          nxt = nxt + 1'b1;
        end
        shadow_exp[s] = nxt;
        run_beats[run_beats.size() - 1].last_of_run = 1'b1;
      end
    end
  endfunction

  function automatic item_t pack_item(input int s, input logic [SEQ_BITS-1:0] q,
                                      input logic [PAY_BITS-1:0] p);
    item_t m;
    m.stream_number   = s[STREAM_BITS-1:0];
    m.sequence_number = q;
    m.message_payload = p;
    return m;
  endfunction

  function automatic logic [PAY_BITS-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic add_row(input int s, input logic [SEQ_BITS-1:0] q,
                         input logic [PAY_BITS-1:0] p, input logic typed, input outcome_e want);
    stim_row_t row;
    row.msg   = pack_item(s, q, p);
    row.typed = typed;
    row.want  = want;
    directed_rows.push_back(row);
  endtask

  // Present one message and hold it until the block takes it.
  task automatic offer_item(input item_t m);
    start <= 1'b1;
    item  <= m;
    do @(posedge clk); while (busy);
  endtask

  // Send one row, log what it owes, then either keep the burst going or idle.
  task automatic deliver(input stim_row_t row);
    result_t echo;
    offer_item(row.msg);
    predict_delivery(row.msg);
    if (row.typed) begin
      echo.outcome      = row.want;
      echo.out_stream   = row.msg.stream_number;
      echo.out_sequence = row.msg.sequence_number;
      echo.out_payload  = row.msg.message_payload & PAY_MASK;
      echo.last_of_run  = 1'b1;
      pending_beats.push_back(echo);
    end else begin
      foreach (run_beats[i]) pending_beats.push_back(run_beats[i]);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
    end
  endtask

  task automatic send_plain(input int s, input logic [SEQ_BITS-1:0] q);
    stim_row_t row;
    row.msg   = pack_item(s, q, rand_payload());
    row.typed = 1'b0;
    row.want  = OUT_RELEASED;
    deliver(row);
    random_items++;
  endtask

  // Stop sending until the block has paid every beat it owes.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_beats.size() != 0);
  endtask

  // Compare each result beat against the oldest owed beat.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_beats.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected beat: outcome %0d stream %0d seq %0h pay %h last %b",
                   result.outcome, result.out_stream, result.out_sequence,
                   result.out_payload, result.last_of_run);
        mismatch_count++;
      end else begin
        head_beat = pending_beats.pop_front();
        if (result.outcome !== head_beat.outcome ||
            result.out_stream !== head_beat.out_stream ||
            result.out_sequence !== head_beat.out_sequence ||
            result.out_payload !== head_beat.out_payload ||
            result.last_of_run !== head_beat.last_of_run) begin
          if (mismatch_count < 10)
            $display("beat mismatch: want outcome %0d stream %0d seq %0h pay %h last %b; ",
                     head_beat.outcome, head_beat.out_stream, head_beat.out_sequence,
                     head_beat.out_payload, head_beat.last_of_run,
                     "got outcome %0d stream %0d seq %0h pay %h last %b",
                     result.outcome, result.out_stream, result.out_sequence,
                     result.out_payload, result.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end a hung run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int                  s;
    int                  k;
    int                  j;
    int                  kind;
    int                  ring_at;
    bit                  ring_done;
    logic [SEQ_BITS-1:0] base;
    logic [SEQ_BITS-1:0] tmp;
    logic [SEQ_BITS-1:0] window[$];

    for (int st = 0; st < STREAMS; st++) begin
      shadow_exp[st] = 1;
      for (int d = 0; d < DEPTH; d++) begin
        ring_seq[st][d]  = '0;
        ring_pay[st][d]  = '0;
        ring_full[st][d] = 1'b0;
      end
    end

    // Bad streams: zero, all ones, one past the last stream.
    add_row(0, 5, '1, 1'b1, OUT_BAD_STREAM);
    add_row(31, 31'h7FFF_FFFF, '0, 1'b1, OUT_BAD_STREAM);
    add_row(STREAMS + 1, 1, 64'h5A5A_5A5A_A5A5_A5A5, 1'b1, OUT_BAD_STREAM);
    // Below the reset expectation, then a plain in-order release and its repeat.
    add_row(1, 0, 64'h1, 1'b1, OUT_DUPLICATE);
    add_row(1, 1, 64'h0123_4567_89AB_CDEF, 1'b1, OUT_RELEASED);
    add_row(1, 1, '1, 1'b1, OUT_DUPLICATE);
    // Largest sequence number parks in the top slot.
    add_row(5, 31'h7FFF_FFFF, '1, 1'b1, OUT_BUFFERED);
    // Stream 2: gap at 5, and 34 shares slot 2 so the first release meets a
    // stale entry and stops.
    add_row(2, 3, 64'hCAFE_0000_0000_0003, 1'b1, OUT_BUFFERED);
    add_row(2, 4, 64'hCAFE_0000_0000_0004, 1'b1, OUT_BUFFERED);
    add_row(2, 6, 64'hCAFE_0000_0000_0006, 1'b1, OUT_BUFFERED);
    add_row(2, 34, 64'hCAFE_0000_0000_0022, 1'b1, OUT_BUFFERED);
    add_row(2, 1, 64'hBEEF_0000_0000_0001, 1'b0, OUT_RELEASED);
    add_row(2, 2, 64'hBEEF_0000_0000_0002, 1'b0, OUT_RELEASED);
    add_row(2, 5, 64'hBEEF_0000_0000_0005, 1'b0, OUT_RELEASED);
    // Stream 3: overwrite a slot with the same number, then with another one.
    add_row(3, 2, 64'h1111_1111_1111_1111, 1'b1, OUT_BUFFERED);
    add_row(3, 2, 64'h2222_2222_2222_2222, 1'b1, OUT_BUFFERED);
    add_row(3, 3, 64'h3333_3333_3333_3333, 1'b1, OUT_BUFFERED);
    add_row(3, 35, 64'h4444_4444_4444_4444, 1'b1, OUT_BUFFERED);
    add_row(3, 1, 64'h5555_5555_5555_5555, 1'b0, OUT_RELEASED);
    add_row(3, 3, 64'h6666_6666_6666_6666, 1'b0, OUT_RELEASED);
    add_row(4, 1, '0, 1'b1, OUT_RELEASED);
    add_row(5, 1, '1, 1'b1, OUT_RELEASED);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) deliver(directed_rows[r]);
    hold_until_drained();

    ring_at   = $urandom_range(10, 60);
    ring_done = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      if (!ring_done && random_items >= ring_at) begin
        // Fill a whole ring out of order, then release: longest possible run.
        hold_until_drained();
        s    = $urandom_range(1, STREAMS);
        base = shadow_exp[s - 1];
        window.delete();
        for (int i = 1; i <= DEPTH; i++) window.push_back(base + i);
        for (int i = DEPTH - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = window[i];
          window[i] = window[j];
          window[j] = tmp;
        end
        foreach (window[i]) send_plain(s, window[i]);
        send_plain(s, base);
        ring_done = 1'b1;
      end else begin
        kind = $urandom_range(0, 9);
        s    = $urandom_range(1, STREAMS);
        base = shadow_exp[s - 1];
        case (kind)
          0: begin
            s = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(STREAMS + 1, 31);
            send_plain(s, $urandom);
          end
          1: send_plain(s, $urandom_range(0, int'(base) - 1));
          2: send_plain(s, $urandom);
          3: send_plain(s, base + DEPTH * $urandom_range(1, 3) + $urandom_range(0, 3));
          default: begin
            // Consecutive numbers from the expected one, shuffled, with an
            // occasional repeat that lands as an overwrite or a duplicate.
            k = $urandom_range(1, 8);
            window.delete();
            for (int i = 0; i < k; i++) window.push_back(base + i);
            if ($urandom_range(0, 3) == 0) window.push_back(base + $urandom_range(0, k - 1));
            for (int i = window.size() - 1; i > 0; i--) begin
              j = $urandom_range(0, i);
              tmp = window[i];
              window[i] = window[j];
              window[j] = tmp;
            end
            foreach (window[i]) send_plain(s, window[i]);
          end
        endcase
      end
    end

    // Drain, then watch a while longer for stray beats.
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
